### rtl/dtq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the deadline timer queue.
package dtq_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int TIME_W      = 48;
  localparam int ID_W        = 32;
  localparam int DELAY_W     = 32;
  localparam int MIN_W       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DUE_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [MIN_W-1:0]  MIN_DELAY_RESET = MIN_W'(100);
  localparam logic [CNT_W-1:0]  FULL_COUNT      = CNT_W'(DEPTH);
  localparam logic [DUE_W-1:0]  DUE_LIMIT       = DUE_W'(MAX_RESULTS);
  localparam logic [TIME_W-1:0] DELAY_SAT       = TIME_W'({DELAY_W{1'b1}});

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_CAN_SCAN,
    S_TICK_POP,
    S_TICK_CHECK,
    S_DELAY,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } store_op_t;

  typedef struct packed {
    store_op_t        op;
    logic [IDX_W-1:0] pos;
  } store_cmd_t;

endpackage

### rtl/dtq_sub.sv
`timescale 1ns / 1ps
// Shared subtractor used for the expiry, id and deadline compares and the rearm delay.
module dtq_sub (
  input  logic [dtq_pkg::TIME_W-1:0] a,
  input  logic [dtq_pkg::TIME_W-1:0] b,
  output logic [dtq_pkg::TIME_W-1:0] diff,
  output logic                       borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

### rtl/dtq_store.sv
`timescale 1ns / 1ps
// Sorted timer entry storage with shift insert and shift remove.
module dtq_store (
  input  logic                          clk,
  input  logic                          rst,
  input  dtq_pkg::store_cmd_t           cmd,
  input  logic [dtq_pkg::TIME_W-1:0]    wr_expiry,
  input  logic [dtq_pkg::ID_W-1:0]      wr_ident,
  input  logic [dtq_pkg::IDX_W-1:0]     rd_pos,
  output logic [dtq_pkg::TIME_W-1:0]    rd_expiry,
  output logic [dtq_pkg::ID_W-1:0]      rd_ident,
  output logic [dtq_pkg::TIME_W-1:0]    head_expiry,
  output logic [dtq_pkg::ID_W-1:0]      head_ident,
  output logic [dtq_pkg::CNT_W-1:0]     count
);

  logic [dtq_pkg::TIME_W-1:0] expiry [dtq_pkg::DEPTH];
  logic [dtq_pkg::ID_W-1:0]   ident  [dtq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        dtq_pkg::OP_INSERT: count <= count + 1'b1;
        dtq_pkg::OP_REMOVE: count <= count - 1'b1;
        default:            count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < dtq_pkg::DEPTH; i++) begin
      if (cmd.op == dtq_pkg::OP_INSERT) begin
        if (dtq_pkg::IDX_W'(i) == cmd.pos) begin
          expiry[i] <= wr_expiry;
          ident[i]  <= wr_ident;
        end else if (dtq_pkg::IDX_W'(i) > cmd.pos) begin
          expiry[i] <= expiry[(i > 0) ? i - 1 : 0];
          ident[i]  <= ident[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.op == dtq_pkg::OP_REMOVE) begin
        if (dtq_pkg::IDX_W'(i) >= cmd.pos && i < dtq_pkg::DEPTH - 1) begin
          expiry[i] <= expiry[(i < dtq_pkg::DEPTH - 1) ? i + 1 : i];
          ident[i]  <= ident[(i < dtq_pkg::DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign rd_expiry   = expiry[rd_pos];
  assign rd_ident    = ident[rd_pos];
  assign head_expiry = expiry[0];
  assign head_ident  = ident[0];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= dtq_pkg::FULL_COUNT)
    else $error("entry count above depth");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.op == dtq_pkg::OP_INSERT |-> count != dtq_pkg::FULL_COUNT)
    else $error("insert into full store");

  a_no_remove_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == dtq_pkg::OP_REMOVE |-> count != '0)
    else $error("remove from empty store");
`endif

endmodule

### rtl/deadline_timer_queue_core.sv
`timescale 1ns / 1ps
// Top level: sequencer for add, cancel and tick over the sorted timer store.
// Add scans to the insert position, inserts and returns the new id; full add returns FULL.
// Cancel scans for the id and removes it; a miss scans all entries, returns NOT_FOUND.
// Tick returns each fired entry, the last with the rearm delay; empty tick returns EMPTY.
// One shared subtractor; next item is accepted the cycle after the final transfer.
// Synchronous reset empties the queue, zeroes the id counter, min delay to 100.
module deadline_timer_queue_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dtq_pkg::MIN_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [dtq_pkg::ID_W-1:0]      timer_id,
  input  logic [dtq_pkg::TIME_W-1:0]    expire_time,
  input  logic [dtq_pkg::TIME_W-1:0]    now_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [dtq_pkg::ID_W-1:0]      result_id,
  output logic                          armed,
  output logic [dtq_pkg::DELAY_W-1:0]   rearm_delay,
  output logic                          last
);

  dtq_pkg::state_t state, state_next;

  logic [dtq_pkg::MIN_W-1:0]   min_delay;
  logic [dtq_pkg::ID_W-1:0]    next_ident, next_ident_next;
  logic [dtq_pkg::ID_W-1:0]    req_id, req_id_next;
  logic [dtq_pkg::TIME_W-1:0]  req_expiry, req_expiry_next;
  logic [dtq_pkg::TIME_W-1:0]  req_now, req_now_next;
  logic [dtq_pkg::CNT_W-1:0]   scan, scan_next;
  logic [dtq_pkg::DUE_W-1:0]   due, due_next;
  logic [dtq_pkg::ID_W-1:0]    hold_id, hold_id_next;
  logic [1:0]                  res_status, res_status_next;
  logic [dtq_pkg::ID_W-1:0]    res_id, res_id_next;
  logic                        res_armed, res_armed_next;
  logic [dtq_pkg::DELAY_W-1:0] res_delay, res_delay_next;
  logic                        res_last, res_last_next;

  dtq_pkg::store_cmd_t         cmd;
  logic [dtq_pkg::TIME_W-1:0]  rd_expiry, head_expiry;
  logic [dtq_pkg::ID_W-1:0]    rd_ident, head_ident;
  logic [dtq_pkg::CNT_W-1:0]   count;

  logic [dtq_pkg::TIME_W-1:0]  sub_a, sub_b, diff, wait_time;
  logic                        borrow;

  dtq_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .wr_expiry   (req_expiry),
    .wr_ident    (next_ident),
    .rd_pos      (scan[dtq_pkg::IDX_W-1:0]),
    .rd_expiry   (rd_expiry),
    .rd_ident    (rd_ident),
    .head_expiry (head_expiry),
    .head_ident  (head_ident),
    .count       (count)
  );

  dtq_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (diff),
    .borrow (borrow)
  );

  always_comb begin
    case (state)
      dtq_pkg::S_ADD_SCAN: begin
        sub_a = req_expiry;
        sub_b = rd_expiry;
      end
      dtq_pkg::S_CAN_SCAN: begin
        sub_a = dtq_pkg::TIME_W'(req_id);
        sub_b = dtq_pkg::TIME_W'(rd_ident);
      end
      dtq_pkg::S_TICK_CHECK: begin
        sub_a = req_now;
        sub_b = head_expiry;
      end
      default: begin
        sub_a = head_expiry;
        sub_b = req_now;
      end
    endcase
  end

  assign wait_time = borrow ? '0 : diff;

  always_comb begin
    state_next      = state;
    next_ident_next = next_ident;
    req_id_next     = req_id;
    req_expiry_next = req_expiry;
    req_now_next    = req_now;
    scan_next       = scan;
    due_next        = due;
    hold_id_next    = hold_id;
    res_status_next = res_status;
    res_id_next     = res_id;
    res_armed_next  = res_armed;
    res_delay_next  = res_delay;
    res_last_next   = res_last;
    cmd.op          = dtq_pkg::OP_NONE;
    cmd.pos         = scan[dtq_pkg::IDX_W-1:0];
    in_stall        = (state != dtq_pkg::S_IDLE);
    out_valid       = (state == dtq_pkg::S_OUT);

    unique case (state)
      dtq_pkg::S_IDLE: begin
        if (in_valid) begin
          req_id_next     = timer_id;
          req_expiry_next = expire_time;
          req_now_next    = now_time;
          scan_next       = '0;
          due_next        = '0;
          unique case (dtq_pkg::kind_t'(kind))
            dtq_pkg::KIND_ADD: begin
              if (count == dtq_pkg::FULL_COUNT) begin
                res_status_next = dtq_pkg::ST_FULL;
                res_id_next     = '0;
                state_next      = dtq_pkg::S_DELAY;
              end else begin
                next_ident_next = next_ident + 1'b1;
                res_id_next     = next_ident + 1'b1;
                state_next      = dtq_pkg::S_ADD_SCAN;
              end
            end
            dtq_pkg::KIND_CANCEL: begin
              state_next = dtq_pkg::S_CAN_SCAN;
            end
            dtq_pkg::KIND_TICK: begin
              if (count == '0) begin
                res_status_next = dtq_pkg::ST_EMPTY;
                res_id_next     = '0;
                state_next      = dtq_pkg::S_DELAY;
              end else begin
                state_next = dtq_pkg::S_TICK_POP;
              end
            end
            default: state_next = dtq_pkg::S_IDLE;
          endcase
        end
      end
      dtq_pkg::S_ADD_SCAN: begin
        if (scan == count || borrow) begin
          cmd.op          = dtq_pkg::OP_INSERT;
          res_status_next = dtq_pkg::ST_OK;
          state_next      = dtq_pkg::S_DELAY;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      dtq_pkg::S_CAN_SCAN: begin
        if (scan == count) begin
          res_status_next = dtq_pkg::ST_NOT_FOUND;
          res_id_next     = req_id;
          state_next      = dtq_pkg::S_DELAY;
        end else if (diff == '0) begin
          cmd.op          = dtq_pkg::OP_REMOVE;
          res_status_next = dtq_pkg::ST_OK;
          res_id_next     = req_id;
          state_next      = dtq_pkg::S_DELAY;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      dtq_pkg::S_TICK_POP: begin
        hold_id_next = head_ident;
        cmd.op       = dtq_pkg::OP_REMOVE;
        cmd.pos      = '0;
        due_next     = due + 1'b1;
        state_next   = dtq_pkg::S_TICK_CHECK;
      end
      dtq_pkg::S_TICK_CHECK: begin
        res_status_next = dtq_pkg::ST_OK;
        res_id_next     = hold_id;
        if (count != '0 && due != dtq_pkg::DUE_LIMIT && !borrow) begin
          res_armed_next = 1'b0;
          res_delay_next = '0;
          res_last_next  = 1'b0;
          state_next     = dtq_pkg::S_OUT;
        end else begin
          state_next = dtq_pkg::S_DELAY;
        end
      end
      dtq_pkg::S_DELAY: begin
        res_last_next = 1'b1;
        if (count == '0) begin
          res_armed_next = 1'b0;
          res_delay_next = '0;
        end else begin
          res_armed_next = 1'b1;
          if (wait_time < dtq_pkg::TIME_W'(min_delay)) begin
            res_delay_next = dtq_pkg::DELAY_W'(min_delay);
          end else if (wait_time > dtq_pkg::DELAY_SAT) begin
            res_delay_next = '1;
          end else begin
            res_delay_next = wait_time[dtq_pkg::DELAY_W-1:0];
          end
        end
        state_next = dtq_pkg::S_OUT;
      end
      dtq_pkg::S_OUT: begin
        if (!out_stall) begin
          state_next = res_last ? dtq_pkg::S_IDLE : dtq_pkg::S_TICK_POP;
        end
      end
      default: state_next = dtq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dtq_pkg::S_IDLE;
      next_ident <= '0;
      min_delay  <= dtq_pkg::MIN_DELAY_RESET;
    end else begin
      state      <= state_next;
      next_ident <= next_ident_next;
      if (cfg_wr_en) begin
        min_delay <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_id     <= req_id_next;
    req_expiry <= req_expiry_next;
    req_now    <= req_now_next;
    scan       <= scan_next;
    due        <= due_next;
    hold_id    <= hold_id_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_armed  <= res_armed_next;
    res_delay  <= res_delay_next;
    res_last   <= res_last_next;
  end

  assign status      = res_status;
  assign result_id   = res_id;
  assign armed       = res_armed;
  assign rearm_delay = res_delay;
  assign last        = res_last;

`ifndef SYNTHESIS
  a_partial_unarmed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !armed && rearm_delay == '0)
    else $error("non-final result carries a deadline");

  a_partial_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> state == dtq_pkg::S_TICK_POP)
    else $error("tick did not continue after a non-final transfer");

  a_ident_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == dtq_pkg::KIND_ADD && count != dtq_pkg::FULL_COUNT
    |=> next_ident == dtq_pkg::ID_W'($past(next_ident) + 1'b1))
    else $error("id counter did not advance on add");

  a_armed_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> armed == (count != '0))
    else $error("armed flag disagrees with queue contents");
`endif

endmodule
